>>> hdl/rcyl_pkg.sv
package rcyl_pkg;

   localparam int RADIUS_W = 24;
   localparam int POS_W    = 32;
   localparam int DIR_W    = 32;
   localparam int DIST_W   = 32;
   localparam int A20_W    = 39;
   localparam int B_W      = 61;
   localparam int SQ_W     = 31;
   localparam int SQ_V_W   = 62;
   localparam int NUM_W    = 40;
   localparam int REQ_W    = 160;
   localparam int RSP_W    = 72;

   localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;
   localparam logic [DIST_W-1:0] DIST_INF = '1;

   typedef struct packed {
      logic                    is_inside;
      logic                    no_root;
      logic signed [A20_W-1:0] a20;
      logic [B_W-1:0]          b;
   } front_side_type;

   typedef struct packed {
      logic is_inside;
      logic near_valid;
      logic next_valid;
   } div_side_type;

endpackage

>>> hdl/ray_cylinder_intersection.sv
// Intersects rays with a vertical infinite cylinder centered on the z axis.
// One ray enters as a beat on the req_ channel: origin x and y (Q16.16) and
// a unit direction (Q2.30). One result beat leaves on the rsp_ channel for
// every ray, in order: the inside flag and the nearest and next forward
// distances (Q16.16, saturated), each with its valid flag.
// The cylinder radius (Q8.16) is written through csr_we and csr_wdata; the
// user must write it only while no ray is in flight, as the block itself
// does not enforce this. Reset sets it to one meter.
// A request beat passes through the product and sum stages, the square root
// stages (one root bit per stage), the root selection stage, the division
// stages (one quotient bit per stage for both distances) and the output
// register. A new ray is accepted in every cycle unless the skid is full.
// When rsp_tready is low, the result in the output register waits and one
// further result is caught in a skid register; only then does req_tready fall
// and the whole pipeline hold. No beat is lost or repeated.
// Reset clears all valid bits, so no beat is in flight afterwards.
module ray_cylinder_intersection (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // origin_x, origin_y, dir_x, dir_y, dir_z
   input  logic [rcyl_pkg::REQ_W-1:0]         req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // inside_res, nearest_valid, nearest_dist, next_valid, next_dist, zero fill
   output logic [rcyl_pkg::RSP_W-1:0]         rsp_tdata,
   input  logic                               csr_we,
   input  logic [rcyl_pkg::RADIUS_W-1:0]      csr_wdata
);
   import rcyl_pkg::*;

   logic [RADIUS_W-1:0] radius_ff;
   logic                ce;

   logic                fr_valid;
   logic [SQ_V_W-1:0]   fr_v;
   front_side_type      fr_side;

   logic                sq_valid;
   logic [SQ_W-1:0]     sq_root;
   front_side_type      sq_side;

   logic signed [NUM_W-1:0] n1, n2;
   logic                n1_pos, n2_pos;
   logic                dec_valid_ff;
   logic [NUM_W-1:0]    dec_near_ff, dec_next_ff;
   logic [B_W-1:0]      dec_b_ff;
   div_side_type        dec_side_ff;

   logic                dv_valid;
   logic [DIST_W-1:0]   dv_near_q, dv_next_q;
   logic                dv_near_sat, dv_next_sat;
   div_side_type        dv_side;

   logic [RSP_W-1:0]    result;
   logic [DIST_W-1:0]   near_dist, next_dist;
   logic                rsp_valid_ff, skid_valid_ff;
   logic [RSP_W-1:0]    rsp_data_ff, skid_data_ff;

   assign ce         = ~skid_valid_ff;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_W'(65536);
      end else if (csr_we) begin
         radius_ff <= csr_wdata;
      end
   end

   rcyl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (req_tvalid & req_tready),
      .in_px     (req_tdata[31:0]),
      .in_py     (req_tdata[63:32]),
      .in_dx     (req_tdata[95:64]),
      .in_dy     (req_tdata[127:96]),
      .in_dz     (req_tdata[159:128]),
      .in_radius (radius_ff),
      .out_valid (fr_valid),
      .out_v     (fr_v),
      .out_side  (fr_side)
   );

   rcyl_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (fr_valid),
      .in_v      (fr_v),
      .in_side   (fr_side),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   assign n1     = {sq_side.a20[A20_W-1], sq_side.a20} + $signed({9'd0, sq_root});
   assign n2     = {sq_side.a20[A20_W-1], sq_side.a20} - $signed({9'd0, sq_root});
   assign n1_pos = ~n1[NUM_W-1] & (n1 != '0);
   assign n2_pos = ~n2[NUM_W-1] & (n2 != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         dec_valid_ff <= 1'b0;
      end else if (ce) begin
         dec_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         dec_b_ff    <= sq_side.b;
         dec_next_ff <= n1;
         dec_near_ff <= n2_pos ? n2 : n1;
         if (sq_side.no_root) begin
            dec_side_ff <= '{is_inside: sq_side.is_inside, near_valid: 1'b0,
                             next_valid: 1'b0};
         end else begin
            dec_side_ff <= '{is_inside: sq_side.is_inside & n1_pos, near_valid: n1_pos,
                             next_valid: n1_pos & n2_pos};
         end
      end
   end

   rcyl_div u_div (
      .clock        (clock),
      .reset        (reset),
      .ce           (ce),
      .in_valid     (dec_valid_ff),
      .in_num_near  (dec_near_ff),
      .in_num_next  (dec_next_ff),
      .in_b         (dec_b_ff),
      .in_side      (dec_side_ff),
      .out_valid    (dv_valid),
      .out_near_q   (dv_near_q),
      .out_next_q   (dv_next_q),
      .out_near_sat (dv_near_sat),
      .out_next_sat (dv_next_sat),
      .out_side     (dv_side)
   );

   assign near_dist = (dv_side.near_valid & ~dv_near_sat) ? dv_near_q : DIST_INF;
   assign next_dist = (dv_side.next_valid & ~dv_next_sat) ? dv_next_q : DIST_INF;
   assign result    = {5'd0, next_dist, dv_side.next_valid, near_dist,
                       dv_side.near_valid, dv_side.is_inside};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (~rsp_valid_ff | rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= dv_valid;
         end
      end else if (dv_valid & ~skid_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (~rsp_valid_ff | rsp_tready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : result;
      end else if (~skid_valid_ff) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/rcyl_front.sv
module rcyl_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              ce,
   input  logic                              in_valid,
   input  logic signed [31:0]                in_px,
   input  logic signed [31:0]                in_py,
   input  logic signed [31:0]                in_dx,
   input  logic signed [31:0]                in_dy,
   input  logic signed [31:0]                in_dz,
   input  logic [rcyl_pkg::RADIUS_W-1:0]     in_radius,
   output logic                              out_valid,
   output logic [rcyl_pkg::SQ_V_W-1:0]       out_v,
   output rcyl_pkg::front_side_type          out_side
);
   import rcyl_pkg::*;

   logic               s1_valid_ff;
   logic [63:0]        s1_pxpx_ff, s1_pypy_ff, s1_dzdz_ff, s1_dxdx_ff, s1_dydy_ff;
   logic signed [63:0] s1_pxdy_ff, s1_pydx_ff, s1_pxdx_ff, s1_pydy_ff;
   logic [47:0]        s1_rr_ff;

   logic               s2_valid_ff;
   logic [63:0]        s2_p2_ff, s2_s_ff;
   logic [64:0]        s2_c_ff, s2_nega_ff;
   logic               s2_vert_ff;
   logic [B_W-1:0]     s2_b_ff;
   logic [47:0]        s2_rr_ff;
   logic [63:0]        bdiff;

   logic               s3_valid_ff, s3_inside_ff, s3_vert_ff, s3_far_ff;
   logic [29:0]        s3_c20_ff;
   logic [23:0]        s3_s40_ff;
   logic [35:0]        s3_r12_ff;
   logic [A20_W-1:0]   s3_a20_ff;
   logic [B_W-1:0]     s3_b_ff;
   logic [64:0]        cabs;

   logic               s4_valid_ff, s4_inside_ff, s4_vert_ff, s4_far_ff;
   logic [59:0]        s4_pa_ff, s4_pc_ff;
   logic [A20_W-1:0]   s4_a20_ff;
   logic [B_W-1:0]     s4_b_ff;

   logic               s5_valid_ff;
   logic [SQ_V_W-1:0]  s5_v_ff;
   front_side_type     s5_side_ff;
   logic [60:0]        d40;
   logic               neg;

   assign bdiff = ONE_Q60 - s1_dzdz_ff;
   assign cabs  = s2_c_ff[64] ? (65'd0 - s2_c_ff) : s2_c_ff;
   assign d40   = {1'b0, s4_pa_ff} - {1'b0, s4_pc_ff};
   assign neg   = d40[60];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_pxpx_ff <= 64'(in_px) * 64'(in_px);
         s1_pypy_ff <= 64'(in_py) * 64'(in_py);
         s1_dzdz_ff <= 64'(in_dz) * 64'(in_dz);
         s1_dxdx_ff <= 64'(in_dx) * 64'(in_dx);
         s1_dydy_ff <= 64'(in_dy) * 64'(in_dy);
         s1_pxdy_ff <= 64'(in_px) * 64'(in_dy);
         s1_pydx_ff <= 64'(in_py) * 64'(in_dx);
         s1_pxdx_ff <= 64'(in_px) * 64'(in_dx);
         s1_pydy_ff <= 64'(in_py) * 64'(in_dy);
         s1_rr_ff   <= {24'd0, in_radius} * {24'd0, in_radius};

         s2_p2_ff   <= s1_pxpx_ff + s1_pypy_ff;
         s2_s_ff    <= s1_dxdx_ff + s1_dydy_ff;
         s2_c_ff    <= {s1_pxdy_ff[63], s1_pxdy_ff} - {s1_pydx_ff[63], s1_pydx_ff};
         s2_nega_ff <= 65'd0 - {s1_pxdx_ff[63], s1_pxdx_ff} - {s1_pydy_ff[63], s1_pydy_ff};
         s2_vert_ff <= s1_dzdz_ff >= ONE_Q60;
         s2_b_ff    <= bdiff[B_W-1:0];
         s2_rr_ff   <= s1_rr_ff;

         s3_inside_ff <= s2_p2_ff <= {16'd0, s2_rr_ff};
         s3_vert_ff   <= s2_vert_ff;
         s3_far_ff    <= |cabs[64:56];
         s3_c20_ff    <= cabs[55:26];
         s3_s40_ff    <= s2_s_ff[63:40];
         s3_r12_ff    <= s2_rr_ff[47:12];
         s3_a20_ff    <= s2_nega_ff[64:26];
         s3_b_ff      <= s2_b_ff;

         s4_pa_ff     <= {24'd0, s3_r12_ff} * {36'd0, s3_s40_ff};
         s4_pc_ff     <= {30'd0, s3_c20_ff} * {30'd0, s3_c20_ff};
         s4_inside_ff <= s3_inside_ff & (s3_vert_ff | ~s3_far_ff);
         s4_vert_ff   <= s3_vert_ff;
         s4_far_ff    <= s3_far_ff;
         s4_a20_ff    <= s3_a20_ff;
         s4_b_ff      <= s3_b_ff;

         s5_v_ff              <= neg ? '0 : {2'b00, d40[59:0]};
         s5_side_ff.is_inside <= s4_inside_ff & (s4_vert_ff | s4_far_ff | ~neg);
         s5_side_ff.no_root   <= s4_vert_ff | s4_far_ff | neg;
         s5_side_ff.a20       <= s4_a20_ff;
         s5_side_ff.b         <= s4_b_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_v     = s5_v_ff;
   assign out_side  = s5_side_ff;

endmodule

>>> hdl/rcyl_sqrt.sv
module rcyl_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [rcyl_pkg::SQ_V_W-1:0]   in_v,
   input  rcyl_pkg::front_side_type      in_side,
   output logic                          out_valid,
   output logic [rcyl_pkg::SQ_W-1:0]     out_root,
   output rcyl_pkg::front_side_type      out_side
);
   import rcyl_pkg::*;

   localparam int RW = SQ_W + 3;

   logic                 val_ff  [1:SQ_W];
   logic [RW-1:0]        rem_ff  [1:SQ_W];
   logic [SQ_W-1:0]      root_ff [1:SQ_W];
   logic [SQ_V_W-1:0]    v_ff    [1:SQ_W];
   front_side_type       side_ff [1:SQ_W];

   for (genvar g = 0; g < SQ_W; g++) begin : g_stage
      localparam int J = SQ_W - 1 - g;
      logic            val_cur;
      logic [RW-1:0]   r_cur, r_sh, t, r_nx;
      logic [SQ_W-1:0] q_cur, q_nx;
      logic [SQ_V_W-1:0] v_cur;
      front_side_type  side_cur;

      if (g == 0) begin : g_first
         assign val_cur  = in_valid;
         assign r_cur    = '0;
         assign q_cur    = '0;
         assign v_cur    = in_v;
         assign side_cur = in_side;
      end else begin : g_next
         assign val_cur  = val_ff[g];
         assign r_cur    = rem_ff[g];
         assign q_cur    = root_ff[g];
         assign v_cur    = v_ff[g];
         assign side_cur = side_ff[g];
      end

      always_comb begin
         r_sh = {r_cur[RW-3:0], v_cur[2*J+1 -: 2]};
         t    = {1'b0, q_cur, 2'b01};
         if (r_sh >= t) begin
            r_nx = r_sh - t;
            q_nx = {q_cur[SQ_W-2:0], 1'b1};
         end else begin
            r_nx = r_sh;
            q_nx = {q_cur[SQ_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[g+1] <= 1'b0;
         end else if (ce) begin
            val_ff[g+1] <= val_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[g+1]  <= r_nx;
            root_ff[g+1] <= q_nx;
            v_ff[g+1]    <= v_cur;
            side_ff[g+1] <= side_cur;
         end
      end
   end

   assign out_valid = val_ff[SQ_W];
   assign out_root  = root_ff[SQ_W];
   assign out_side  = side_ff[SQ_W];

endmodule

>>> hdl/rcyl_div.sv
module rcyl_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          ce,
   input  logic                          in_valid,
   input  logic [rcyl_pkg::NUM_W-1:0]    in_num_near,
   input  logic [rcyl_pkg::NUM_W-1:0]    in_num_next,
   input  logic [rcyl_pkg::B_W-1:0]      in_b,
   input  rcyl_pkg::div_side_type        in_side,
   output logic                          out_valid,
   output logic [rcyl_pkg::DIST_W-1:0]   out_near_q,
   output logic [rcyl_pkg::DIST_W-1:0]   out_next_q,
   output logic                          out_near_sat,
   output logic                          out_next_sat,
   output rcyl_pkg::div_side_type        out_side
);
   import rcyl_pkg::*;

   localparam int QW = DIST_W;

   logic              val_ff  [0:QW];
   logic [B_W-1:0]    rn_ff   [0:QW];
   logic [B_W-1:0]    rx_ff   [0:QW];
   logic [QW-1:0]     qn_ff   [0:QW];
   logic [QW-1:0]     qx_ff   [0:QW];
   logic              sn_ff   [0:QW];
   logic              sx_ff   [0:QW];
   logic [B_W-1:0]    b_ff    [0:QW];
   div_side_type      side_ff [0:QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (ce) begin
         val_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         sn_ff[0]   <= {in_num_near, 24'd0} >= {3'd0, in_b};
         sx_ff[0]   <= {in_num_next, 24'd0} >= {3'd0, in_b};
         rn_ff[0]   <= {in_num_near[B_W-25:0], 24'd0};
         rx_ff[0]   <= {in_num_next[B_W-25:0], 24'd0};
         qn_ff[0]   <= '0;
         qx_ff[0]   <= '0;
         b_ff[0]    <= in_b;
         side_ff[0] <= in_side;
      end
   end

   for (genvar g = 0; g < QW; g++) begin : g_stage
      logic [B_W:0]   n_sh, x_sh, n_sub, x_sub;
      logic           n_ge, x_ge;

      always_comb begin
         n_sh  = {rn_ff[g], 1'b0};
         x_sh  = {rx_ff[g], 1'b0};
         n_ge  = n_sh >= {1'b0, b_ff[g]};
         x_ge  = x_sh >= {1'b0, b_ff[g]};
         n_sub = n_ge ? (n_sh - {1'b0, b_ff[g]}) : n_sh;
         x_sub = x_ge ? (x_sh - {1'b0, b_ff[g]}) : x_sh;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[g+1] <= 1'b0;
         end else if (ce) begin
            val_ff[g+1] <= val_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rn_ff[g+1]   <= n_sub[B_W-1:0];
            rx_ff[g+1]   <= x_sub[B_W-1:0];
            qn_ff[g+1]   <= {qn_ff[g][QW-2:0], n_ge};
            qx_ff[g+1]   <= {qx_ff[g][QW-2:0], x_ge};
            sn_ff[g+1]   <= sn_ff[g];
            sx_ff[g+1]   <= sx_ff[g];
            b_ff[g+1]    <= b_ff[g];
            side_ff[g+1] <= side_ff[g];
         end
      end
   end

   assign out_valid    = val_ff[QW];
   assign out_near_q   = qn_ff[QW];
   assign out_next_q   = qx_ff[QW];
   assign out_near_sat = sn_ff[QW];
   assign out_next_sat = sx_ff[QW];
   assign out_side     = side_ff[QW];

endmodule

>>> tb/sv/tb_ray_cylinder_intersection.sv
module tb_ray_cylinder_intersection;
   import rcyl_pkg::*;

   localparam longint unsigned UNIT_Q60 = 64'h1000_0000_0000_0000;
   localparam longint unsigned FAR_MISS = 64'h0100_0000_0000_0000;
   localparam longint          DIR_ONE  = 64'sd1073741824;
   localparam longint          POS_MIN  = -64'sd2147483648;

   typedef struct packed {
      logic              is_inside;
      logic              near_valid;
      logic [DIST_W-1:0] near_dist;
      logic              next_valid;
      logic [DIST_W-1:0] next_dist;
   } crossing_type;

   class ray_scoreboard;
      logic [RADIUS_W-1:0] radius;
      crossing_type        crossing_q[$];
      int                  errors;
      int                  beats_checked;

      function new();
         radius = 24'd65536;
         errors = 0;
         beats_checked = 0;
      endfunction

      function automatic longint unsigned int_sqrt(longint unsigned v);
         longint unsigned res;
         longint unsigned bitv;
         res = 0;
         bitv = 64'h4000_0000_0000_0000;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v = v - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      function automatic logic [DIST_W-1:0] scaled_quotient(longint unsigned num,
                                                              longint unsigned den);
         longint unsigned q;
         longint unsigned rem;
         q = num / den;
         rem = num % den;
         if (q > 64'hFFFF_FFFF) return DIST_INF;
         for (int i = 0; i < 56; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q = q | 64'd1;
            end
            if (q > 64'hFFFF_FFFF) return DIST_INF;
         end
         return q[DIST_W-1:0];
      endfunction

      function automatic crossing_type trace_ray(logic [REQ_W-1:0] d);
         crossing_type    e;
         longint          px, py, dx, dy, dz, c, d40, sq, a20, n1, n2;
         longint unsigned r2, p2, dz2, b, cabs, s, c20;
         px = longint'($signed(d[31:0]));
         py = longint'($signed(d[63:32]));
         dx = longint'($signed(d[95:64]));
         dy = longint'($signed(d[127:96]));
         dz = longint'($signed(d[159:128]));
         r2 = longint'(radius) * longint'(radius);
         p2 = longint'(px * px) + longint'(py * py);
         e.is_inside = (p2 <= r2);
         e.near_valid = 1'b0;
         e.next_valid = 1'b0;
         e.near_dist = DIST_INF;
         e.next_dist = DIST_INF;
         dz2 = dz * dz;
         if (dz2 < UNIT_Q60) begin
            b = UNIT_Q60 - dz2;
            c = px * dy - py * dx;
            cabs = (c < 0) ? -c : c;
            if (cabs >= FAR_MISS) begin
               e.is_inside = 1'b0;
            end else begin
               s = (dx * dx) + (dy * dy);
               c20 = cabs >> 26;
               d40 = longint'((r2 >> 12) * (s >> 40)) - longint'(c20 * c20);
               if (d40 < 0) begin
                  e.is_inside = 1'b0;
               end else begin
                  sq = int_sqrt(d40);
                  a20 = (-(px * dx) - py * dy) >>> 26;
                  n1 = a20 + sq;
                  n2 = a20 - sq;
                  if (n1 <= 0) begin
                     e.is_inside = 1'b0;
                  end else if (n2 <= 0) begin
                     e.near_valid = 1'b1;
                     e.near_dist = scaled_quotient(n1, b);
                  end else begin
                     e.near_valid = 1'b1;
                     e.near_dist = scaled_quotient(n2, b);
                     e.next_valid = 1'b1;
                     e.next_dist = scaled_quotient(n1, b);
                  end
               end
            end
         end
         return e;
      endfunction

      task note_ray(logic [REQ_W-1:0] d);
         crossing_q.push_back(trace_ray(d));
      endtask

      task report(string what);
         errors++;
         $display("ERROR: beat %0d: %s", beats_checked, what);
      endtask

      task check_result(logic [RSP_W-1:0] r);
         crossing_type e;
         if (crossing_q.size() == 0) begin
            report("result beat with no ray outstanding");
         end else begin
            e = crossing_q.pop_front();
            if (r[0] !== e.is_inside)
               report($sformatf("inside %0b, expected %0b", r[0], e.is_inside));
            if (r[1] !== e.near_valid)
               report($sformatf("nearest_valid %0b, expected %0b", r[1], e.near_valid));
            if (r[33:2] !== e.near_dist)
               report($sformatf("nearest_dist %h, expected %h", r[33:2], e.near_dist));
            if (r[34] !== e.next_valid)
               report($sformatf("next_valid %0b, expected %0b", r[34], e.next_valid));
            if (r[66:35] !== e.next_dist)
               report($sformatf("next_dist %h, expected %h", r[66:35], e.next_dist));
            if (r[71:67] !== 5'd0)
               report("fill bits not zero");
         end
         beats_checked++;
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_we = 1'b0;
   logic [RADIUS_W-1:0] csr_wdata = '0;

   ray_scoreboard sb = new();
   bit            long_stall = 1'b0;
   bit            steady = 1'b0;
   int            rays_sent = 0;

   always #5 clock = ~clock;

   ray_cylinder_intersection i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_ray(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_stall) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            long_stall = 1'b0;
         end
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task send_ray(longint ox, longint oy, longint dx, longint dy, longint dz);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dz[31:0], dy[31:0], dx[31:0], oy[31:0], ox[31:0]};
      do @(posedge clock); while (!req_tready);
      rays_sent++;
   endtask

   task drain();
      req_tvalid <= 1'b0;
      while (sb.crossing_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task write_radius(logic [RADIUS_W-1:0] value);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.radius = value;
   endtask

   function automatic longint rand_span(longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   task random_ray(longint r);
      longint span, ox, oy, dx, dy, dz;
      span = 3 * r + 65536;
      if (span > DIR_ONE) span = DIR_ONE;
      if ($urandom_range(0, 9) == 0) begin
         ox = longint'($signed($urandom()));
         oy = longint'($signed($urandom()));
      end else begin
         ox = rand_span(span);
         oy = rand_span(span);
      end
      dx = rand_span(DIR_ONE);
      dy = rand_span(DIR_ONE);
      case ($urandom_range(0, 9))
         0: dz = $urandom_range(0, 1) ? DIR_ONE : -DIR_ONE;
         1, 2: dz = rand_span(DIR_ONE);
         default: dz = rand_span(DIR_ONE / 4);
      endcase
      send_ray(ox, oy, dx, dy, dz);
   endtask

   initial begin
      longint radii [4];
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_ray(0, 0, DIR_ONE, 0, 0);
      send_ray(0, 0, -DIR_ONE, 0, 0);
      send_ray(0, 0, 0, DIR_ONE, 0);
      send_ray(0, 0, 0, -DIR_ONE, 0);
      send_ray(0, 0, 0, 0, DIR_ONE);
      send_ray(0, 0, 0, 0, -DIR_ONE);
      send_ray(-3 * 65536, 0, DIR_ONE, 0, 0);
      send_ray(3 * 65536, 0, DIR_ONE, 0, 0);
      send_ray(-3 * 65536, 65536, DIR_ONE, 0, 0);
      send_ray(-3 * 65536, 2 * 65536, DIR_ONE, 0, 0);
      send_ray(-3 * 65536, 2000 * 65536, DIR_ONE, 0, 0);
      send_ray(-3 * 65536, 0, 759250125, 0, 759250125);
      send_ray(POS_MIN, POS_MIN, DIR_ONE, DIR_ONE, 0);
      send_ray(2147483647, 2147483647, -DIR_ONE, -DIR_ONE, 0);
      send_ray(POS_MIN, 0, DIR_ONE, 0, 0);
      send_ray(2147483647, 0, -DIR_ONE, 0, 1073741823);
      send_ray(0, 65535, DIR_ONE, 0, 0);
      send_ray(-65536, -65536, DIR_ONE, DIR_ONE, -DIR_ONE);
      send_ray(1, -1, -DIR_ONE, DIR_ONE, 1);
      send_ray(-65537, 0, DIR_ONE, 0, 1073741823);
      drain();

      radii[0] = 0;
      radii[1] = 24'hFFFFFF;
      radii[2] = 65536;
      radii[3] = $urandom_range(1, 24'hFFFFFF);
      for (int phase = 0; phase < 9; phase++) begin
         longint r;
         r = (phase < 4) ? radii[phase] : $urandom_range(1, 24'h40000);
         write_radius(r[23:0]);
         steady = (phase == 2);
         if (phase == 3) long_stall = 1'b1;
         if (phase == 3) steady = 1'b1;
         for (int i = 0; i < ((phase == 3) ? 130 : 40); i++) random_ray(r);
         steady = 1'b0;
         drain();
      end

      $display("%0d rays sent, %0d result beats checked over nine radius settings",
               rays_sent, sb.beats_checked);
      $display("including zero and full-scale radius, vertical rays and a long output stall");
      if (sb.errors == 0 && sb.crossing_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> ray_cylinder_intersection.f
hdl/rcyl_pkg.sv
hdl/rcyl_front.sv
hdl/rcyl_sqrt.sv
hdl/rcyl_div.sv
hdl/ray_cylinder_intersection.sv
tb/sv/tb_ray_cylinder_intersection.sv
